### design/ged_pkg.sv
// ----------------------------------------------------------------------------
// ged_pkg: shared types and constants for the GPIO event debounce queue
// Action codes, configuration register indexes, controller states, and the
// command/status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ged_pkg;

    // Default sizes of the pin arrays and the event queue
    localparam int PIN_COUNT_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 64;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int PIN_W      = 3;
    localparam int DEBOUNCE_W = 16;
    localparam int ACTIVE_W   = 4;
    localparam int FILL_OUT_W = 7;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 1;

    // Register reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET   = 4'd8;

    // Request actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_POP   = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 1'b0,
        CFG_ACTIVE   = 1'b1
    } t_cfg_idx;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_ctrl_sts;

endpackage

### design/ged_ctrl.sv
// ----------------------------------------------------------------------------
// ged_ctrl: request sequencer
// Takes one request, then applies it once the output
// register can take the result.
// ----------------------------------------------------------------------------
module ged_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ged_pkg::t_ctrl_sts i_sts,
    output ged_pkg::t_ctrl_cmd o_cmd
);
    import ged_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall      = 1'b1;
        o_cmd.load_item = 1'b0;
        o_cmd.exec      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall      = 1'b0;
                o_cmd.load_item = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

### design/ged_datapath.sv
// ----------------------------------------------------------------------------
// ged_datapath: debounce state, counters, event queue and result register
// Holds per-pin lockouts and edge counts, the edge total, the event memory
// with its pointers, the configuration registers and the output register.
// ----------------------------------------------------------------------------
module ged_datapath #(
    parameter int PIN_COUNT   = ged_pkg::PIN_COUNT_DEF,
    parameter int QUEUE_DEPTH = ged_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ged_pkg::t_ctrl_cmd                 i_cmd,
    output ged_pkg::t_ctrl_sts                 o_sts,
    input  logic [ged_pkg::ACTION_W-1:0]       i_action,
    input  logic [ged_pkg::PIN_W-1:0]          i_pin,
    input  logic                               i_cfg_we,
    input  logic [ged_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ged_pkg::DEBOUNCE_W-1:0]     i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_accepted,
    output logic                               o_dropped,
    output logic                               o_popped_valid,
    output logic [ged_pkg::PIN_W-1:0]          o_popped_pin,
    output logic [ged_pkg::FILL_OUT_W-1:0]     o_queue_fill,
    output logic [ged_pkg::COUNT_W-1:0]        o_total_count,
    output logic [ged_pkg::COUNT_W-1:0]        o_pin_count
);
    import ged_pkg::*;

    localparam int PIN_IW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int QW     = $clog2(QUEUE_DEPTH);
    localparam int FW     = $clog2(QUEUE_DEPTH + 1);

    // Configuration
    logic [DEBOUNCE_W-1:0] r_debounce;
    logic [ACTIVE_W-1:0]   r_active;

    // Captured request
    t_action           r_action;
    logic [PIN_W-1:0]  r_pin;

    // Debounce and counting state
    logic [DEBOUNCE_W-1:0] r_lockout [PIN_COUNT];
    logic [DEBOUNCE_W-1:0] n_lockout [PIN_COUNT];
    logic [COUNT_W-1:0]    r_count   [PIN_COUNT];
    logic [COUNT_W-1:0]    n_count   [PIN_COUNT];
    logic [COUNT_W-1:0]    r_total;
    logic [COUNT_W-1:0]    n_total;

    // Event queue
    logic [PIN_W-1:0] r_event_mem [QUEUE_DEPTH];
    logic [PIN_W-1:0] r_rd_data;
    logic [QW-1:0]    r_wr_ptr;
    logic [QW-1:0]    n_wr_ptr;
    logic [QW-1:0]    r_rd_ptr;
    logic [QW-1:0]    n_rd_ptr;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;
    logic             wr_en;

    // Output register
    logic                  r_out_valid;
    logic                  r_accepted;
    logic                  r_dropped;
    logic                  r_popped_valid;
    logic [PIN_W-1:0]      r_popped_pin;
    logic [FILL_OUT_W-1:0] r_queue_fill;
    logic [COUNT_W-1:0]    r_total_count;
    logic [COUNT_W-1:0]    r_pin_count;

    // Step results
    logic                  n_accepted;
    logic                  n_dropped;
    logic                  n_popped_valid;
    logic [PIN_W-1:0]      n_popped_pin;
    logic                  push;

    // Pin decode
    logic [PIN_IW+PIN_W-1:0]      pin_ext;
    logic [PIN_IW-1:0]            pin_idx;
    logic                         pin_ok;
    logic                         pin_active;
    logic                         edge_ok;
    logic                         full;
    logic [FW+FILL_OUT_W-1:0]     fill_ext;

    assign pin_ext    = {{PIN_IW{1'b0}}, r_pin};
    assign pin_idx    = pin_ext[PIN_IW-1:0];
    assign pin_ok     = pin_ext < (PIN_IW + PIN_W)'(PIN_COUNT);
    assign pin_active = {1'b0, r_pin} < r_active;
    assign edge_ok    = pin_ok && pin_active && (r_lockout[pin_idx] == '0);
    assign full       = r_fill == FW'(QUEUE_DEPTH);

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_active   <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_ACTIVE:   r_active   <= i_cfg_data[ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= t_action'(i_action);
            r_pin    <= i_pin;
        end
    end

    // Apply the request to the state
    always_comb begin
        n_lockout      = r_lockout;
        n_count        = r_count;
        n_total        = r_total;
        n_wr_ptr       = r_wr_ptr;
        n_rd_ptr       = r_rd_ptr;
        n_fill         = r_fill;
        n_accepted     = 1'b0;
        n_dropped      = 1'b0;
        n_popped_valid = 1'b0;
        n_popped_pin   = '0;
        push           = 1'b0;
        case (r_action)
            ACT_TICK: begin
                for (int i = 0; i < PIN_COUNT; i++) begin
                    if (r_lockout[i] != '0) begin
                        n_lockout[i] = r_lockout[i] - DEBOUNCE_W'(1);
                    end
                end
            end
            ACT_EDGE: begin
                if (edge_ok) begin
                    n_accepted         = 1'b1;
                    n_lockout[pin_idx] = r_debounce;
                    n_count[pin_idx]   = r_count[pin_idx] + COUNT_W'(1);
                    n_total            = r_total + COUNT_W'(1);
                    if (!full) begin
                        push     = 1'b1;
                        n_wr_ptr = (r_wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + QW'(1);
                        n_fill   = r_fill + FW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
            end
            ACT_POP: begin
                if (r_fill != '0) begin
                    n_popped_valid = 1'b1;
                    n_popped_pin   = r_rd_data;
                    n_rd_ptr       = (r_rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                        : r_rd_ptr + QW'(1);
                    n_fill         = r_fill - FW'(1);
                end
            end
            ACT_CLEAR: begin
                n_wr_ptr = '0;
                n_rd_ptr = '0;
                n_fill   = '0;
                n_total  = '0;
            end
            default: ;
        endcase
    end

    assign wr_en    = i_cmd.exec && push;
    assign fill_ext = {{FILL_OUT_W{1'b0}}, n_fill};

    // Commit state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_lockout[i] <= '0;
                r_count[i]   <= '0;
            end
            r_total  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else if (i_cmd.exec) begin
            r_lockout <= n_lockout;
            r_count   <= n_count;
            r_total   <= n_total;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_fill    <= n_fill;
        end
    end

    // Event memory: write on push, read the head every cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_event_mem[r_wr_ptr] <= r_pin;
        end
        r_rd_data <= r_event_mem[r_rd_ptr];
    end

    // Output valid: set on a new result, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_accepted     <= n_accepted;
            r_dropped      <= n_dropped;
            r_popped_valid <= n_popped_valid;
            r_popped_pin   <= n_popped_pin;
            r_queue_fill   <= fill_ext[FILL_OUT_W-1:0];
            r_total_count  <= n_total;
            r_pin_count    <= pin_ok ? n_count[pin_idx] : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_dropped      = r_dropped;
    assign o_popped_valid = r_popped_valid;
    assign o_popped_pin   = r_popped_pin;
    assign o_queue_fill   = r_queue_fill;
    assign o_total_count  = r_total_count;
    assign o_pin_count    = r_pin_count;

endmodule

### design/gpio_event_debounce_fifo.sv
// ----------------------------------------------------------------------------
// gpio_event_debounce_fifo: per-pin edge debounce with an event queue
// Requests (i_action, i_pin) arrive on a valid/stall channel: tick, edge,
// pop or clear. Each request yields one result on the output valid/stall
// channel: accept/drop flags, popped pin, queue fill, total and pin counts.
// An item passes the accept state, then the update state set by the
// sequencer, which uses the registered read of the event memory; the result
// is then registered. No new request is taken until the update is applied.
// The next request is taken while a result waits in the output register;
// if the receiver stalls, the update of that request waits and o_in_stall
// stays high until the pending result is taken.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 debounce time,
// 1 active pin count) and i_cfg_data; ready is always high. Write only when
// idle.
// Synchronous active-low reset clears lockouts, counts, queue pointers and
// fill, and loads a debounce time of 50 ticks and 8 active pins. Queue
// contents are not cleared; only entries counted in the fill are ever read.
// ----------------------------------------------------------------------------
module gpio_event_debounce_fifo #(
    parameter int PIN_COUNT   = ged_pkg::PIN_COUNT_DEF,
    parameter int QUEUE_DEPTH = ged_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ged_pkg::ACTION_W-1:0]   i_action,
    input  logic [ged_pkg::PIN_W-1:0]      i_pin,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ged_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ged_pkg::DEBOUNCE_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_accepted,
    output logic                           o_dropped,
    output logic                           o_popped_valid,
    output logic [ged_pkg::PIN_W-1:0]      o_popped_pin,
    output logic [ged_pkg::FILL_OUT_W-1:0] o_queue_fill,
    output logic [ged_pkg::COUNT_W-1:0]    o_total_count,
    output logic [ged_pkg::COUNT_W-1:0]    o_pin_count
);
    import ged_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    assign o_cfg_ready = 1'b1;

    // Request sequencer
    ged_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // State, queue and result register
    ged_datapath #(
        .PIN_COUNT   (PIN_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_pin          (i_pin),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_accepted     (o_accepted),
        .o_dropped      (o_dropped),
        .o_popped_valid (o_popped_valid),
        .o_popped_pin   (o_popped_pin),
        .o_queue_fill   (o_queue_fill),
        .o_total_count  (o_total_count),
        .o_pin_count    (o_pin_count)
    );

endmodule
